// ===== rtl/ulms_pkg.sv =====
// Shared types and constants for the lagged unicycle motion step.
// Used by ulms_mac and unicycle_lagged_motion_step; no dependencies.
package ulms_pkg;

    localparam int MAC_OP_W  = 34;
    localparam int MAC_ACC_W = 68;

    // 2^32 / (2*pi), rounded
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;

    localparam logic [2:0] REG_TIME_STEP       = 3'd0;
    localparam logic [2:0] REG_SPEED_LAG_INV   = 3'd1;
    localparam logic [2:0] REG_YAW_LAG_INV     = 3'd2;
    localparam logic [2:0] REG_START_X         = 3'd3;
    localparam logic [2:0] REG_START_Y         = 3'd4;
    localparam logic [2:0] REG_START_HEADING   = 3'd5;
    localparam logic [2:0] REG_START_SPEED     = 3'd6;
    localparam logic [2:0] REG_START_TURN_RATE = 3'd7;

    typedef struct packed {
        logic               restart;
        logic signed [31:0] speed_cmd;
        logic signed [31:0] turn_rate_cmd;
    } t_in_word;

    typedef struct packed {
        logic        [31:0] elapsed;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [31:0] heading;
        logic signed [31:0] speed;
        logic signed [31:0] turn_rate;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
    } t_out_word;

    // One multiply-accumulate command
    typedef struct packed {
        logic                        clr;
        logic                        neg;
        logic                        sh32;
        logic signed [MAC_OP_W-1:0]  a;
        logic signed [MAC_OP_W-1:0]  b;
    } t_mac_op;

endpackage

// ===== rtl/ulms_mac.sv =====
// Shared two-stage signed multiply-accumulate unit.
// Depends on ulms_pkg for the command type and widths.
module ulms_mac (
    input  logic                                  i_clk,
    input  ulms_pkg::t_mac_op                     i_op,
    output logic signed [ulms_pkg::MAC_ACC_W-1:0] o_acc
);

    logic signed [ulms_pkg::MAC_ACC_W-1:0] r_prod;
    logic signed [ulms_pkg::MAC_ACC_W-1:0] r_acc;
    logic signed [ulms_pkg::MAC_ACC_W-1:0] w_term;
    logic                                  r_clr;
    logic                                  r_neg;
    logic                                  r_sh32;

    always_comb begin
        w_term = r_sh32 ? (r_prod <<< 32) : r_prod;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_op.a * i_op.b;
        r_clr  <= i_op.clr;
        r_neg  <= i_op.neg;
        r_sh32 <= i_op.sh32;
        r_acc  <= (r_clr ? '0 : r_acc) + (r_neg ? -w_term : w_term);
    end

    assign o_acc = r_acc;

endmodule

// ===== rtl/ulms_sine_rom.sv =====
// Registered sine lookup table, Q16 entries, built at elaboration.
// No package dependencies.
module ulms_sine_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    output logic signed [17:0]         o_data
);

    typedef logic signed [17:0] t_rom [DEPTH];

    function automatic logic signed [17:0] poly_sine(input logic [31:0] ang);
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        r = {34'd0, ang[29:0]};
        if (ang[30]) begin
            r = 64'd1073741824 - r;
        end
        x  = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t  = 64'd1073741824;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd110;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s + 64'd8192) >> 14;
        if (s > 64'd65536) begin
            s = 64'd65536;
        end
        return ang[31] ? -$signed(18'(s)) : $signed(18'(s));
    endfunction

    function automatic t_rom build_rom();
        t_rom tab;
        for (int i = 0; i < DEPTH; i++) begin
            tab[i] = poly_sine(32'((64'(i) << 32) / DEPTH));
        end
        return tab;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    always_ff @(posedge i_clk) begin
        o_data <= SINE_ROM[i_addr];
    end

endmodule

// ===== rtl/unicycle_lagged_motion_step.sv =====
// Lagged unicycle motion model, one explicit Euler step per non-restart input word.
// A step word passes through the calculation and finish states, a restart word only
// through the finish state; no new word is taken until the block is idle again. Step
// words run 23 products in turn on the single shared 34x34 multiply-accumulate unit.
// Reset (i_rst_n low, synchronous): pose, speeds and time clear, registers take
// their default values, the output word is dropped and the block goes idle.
module unicycle_lagged_motion_step #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ulms_pkg::t_in_word   i_in_data,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ulms_pkg::t_out_word  o_out_data,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int SIN_AW = $clog2(SINE_TABLE_DEPTH);
    localparam int ACC_W  = ulms_pkg::MAC_ACC_W;
    localparam int OP_W   = ulms_pkg::MAC_OP_W;

    // Sequencer steps. Each issues at most one product; a chain's sum reaches the
    // accumulator output through the product and accumulator registers.
    localparam logic [5:0] STP_VDIF     = 6'd0;
    localparam logic [5:0] STP_WDIF     = 6'd1;
    localparam logic [5:0] STP_ACC_CAP  = 6'd2;
    localparam logic [5:0] STP_ACC_LO   = 6'd3;
    localparam logic [5:0] STP_ACC_HI   = 6'd4;
    localparam logic [5:0] STP_YACC_LO  = 6'd5;
    localparam logic [5:0] STP_YACC_HI  = 6'd6;
    localparam logic [5:0] STP_SPD_DT   = 6'd7;
    localparam logic [5:0] STP_YAW_CAP  = 6'd8;
    localparam logic [5:0] STP_YAW_DT   = 6'd9;
    localparam logic [5:0] STP_SPD_YAW  = 6'd10;
    localparam logic [5:0] STP_DYAW_CAP = 6'd11;
    localparam logic [5:0] STP_DYAW_LO  = 6'd12;
    localparam logic [5:0] STP_DYAW_HI  = 6'd13;
    localparam logic [5:0] STP_HD_CAP   = 6'd15;
    localparam logic [5:0] STP_SIN_ADR  = 6'd16;
    localparam logic [5:0] STP_COS_ADR  = 6'd17;
    localparam logic [5:0] STP_COS_CAP  = 6'd18;
    localparam logic [5:0] STP_QC_LO    = 6'd19;
    localparam logic [5:0] STP_QC_HI    = 6'd20;
    localparam logic [5:0] STP_QS_LO    = 6'd21;
    localparam logic [5:0] STP_QS_HI    = 6'd22;
    localparam logic [5:0] STP_AXC_LO   = 6'd23;
    localparam logic [5:0] STP_AXC_HI   = 6'd24;
    localparam logic [5:0] STP_AXS_LO   = 6'd25;
    localparam logic [5:0] STP_AXS_HI   = 6'd26;
    localparam logic [5:0] STP_AYS_LO   = 6'd27;
    localparam logic [5:0] STP_AYS_HI   = 6'd28;
    localparam logic [5:0] STP_AYC_LO   = 6'd29;
    localparam logic [5:0] STP_AYC_HI   = 6'd30;
    localparam logic [5:0] STP_LAST     = 6'd32;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    // configuration registers
    logic        [15:0] r_time_step;
    logic        [23:0] r_speed_lag_inv;
    logic        [23:0] r_yaw_lag_inv;
    logic signed [31:0] r_start_x;
    logic signed [31:0] r_start_y;
    logic        [31:0] r_start_heading;
    logic signed [31:0] r_start_speed;
    logic signed [31:0] r_start_turn_rate;

    // model state
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic        [31:0] r_hd;
    logic signed [31:0] r_spd;
    logic signed [31:0] r_yaw;
    logic        [31:0] r_time;

    // per-step working values
    logic signed [31:0] r_vcmd;
    logic signed [31:0] r_wcmd;
    logic signed [41:0] r_acc;
    logic signed [41:0] r_yacc;
    logic signed [47:0] r_q;
    logic signed [47:0] r_om;
    logic signed [47:0] r_dyaw;
    logic signed [17:0] r_sin;
    logic signed [17:0] r_cos;
    logic signed [31:0] r_ax;
    logic signed [31:0] r_ay;

    t_state             r_state;
    t_state             n_state;
    logic        [5:0]  r_step;
    logic               r_out_valid;
    ulms_pkg::t_out_word r_out_data;

    ulms_pkg::t_mac_op  w_op;
    logic signed [ACC_W-1:0] w_acc;
    logic        [31:0] w_rom_angle;
    logic        [48:0] w_rom_prod;
    logic signed [17:0] w_rom_data;
    logic               w_in_acc;
    logic               w_out_free;
    logic signed [OP_W-1:0] w_dt;

    function automatic ulms_pkg::t_mac_op mk_op(
        input logic clr, input logic neg, input logic sh32,
        input logic signed [OP_W-1:0] a, input logic signed [OP_W-1:0] b);
        ulms_pkg::t_mac_op op;
        op.clr  = clr;
        op.neg  = neg;
        op.sh32 = sh32;
        op.a    = a;
        op.b    = b;
        return op;
    endfunction

    // low 32 bits as a non-negative operand
    function automatic logic signed [OP_W-1:0] lo32(input logic [31:0] v);
        return $signed({2'b00, v});
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
        logic signed [31:0] res;
        if (v > 70'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -70'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign w_dt        = $signed({18'd0, r_time_step});

    ulms_mac u_mac (
        .i_clk (i_clk),
        .i_op  (w_op),
        .o_acc (w_acc)
    );

    // Table index = floor(angle * depth / 2^32); cosine reads a quarter turn ahead.
    assign w_rom_angle = (r_step == STP_COS_ADR) ? r_hd + ulms_pkg::QUARTER_TURN : r_hd;
    assign w_rom_prod  = 49'(w_rom_angle) * 49'(SINE_TABLE_DEPTH);

    ulms_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_prod[SIN_AW+31:32]),
        .o_data (w_rom_data)
    );

    // Operand selection for the shared multiplier. Wide operands go in as a
    // signed upper part shifted by 32 plus an unsigned lower 32-bit part.
    always_comb begin
        w_op = mk_op(1'b0, 1'b0, 1'b0, '0, '0);
        if (r_state == ST_CALC) begin
            unique case (r_step)
                STP_VDIF:    w_op = mk_op(1'b1, 1'b0, 1'b0, OP_W'(r_vcmd) - OP_W'(r_spd),
                                          $signed({10'd0, r_speed_lag_inv}));
                STP_WDIF:    w_op = mk_op(1'b1, 1'b0, 1'b0, OP_W'(r_wcmd) - OP_W'(r_yaw),
                                          $signed({10'd0, r_yaw_lag_inv}));
                STP_ACC_LO:  w_op = mk_op(1'b1, 1'b0, 1'b0, lo32(r_acc[31:0]), w_dt);
                STP_ACC_HI:  w_op = mk_op(1'b0, 1'b0, 1'b1,
                                          OP_W'($signed(r_acc[41:32])), w_dt);
                STP_YACC_LO: w_op = mk_op(1'b1, 1'b0, 1'b0, lo32(r_yacc[31:0]), w_dt);
                STP_YACC_HI: w_op = mk_op(1'b0, 1'b0, 1'b1,
                                          OP_W'($signed(r_yacc[41:32])), w_dt);
                STP_SPD_DT:  w_op = mk_op(1'b1, 1'b0, 1'b0, OP_W'(r_spd), w_dt);
                STP_YAW_DT:  w_op = mk_op(1'b1, 1'b0, 1'b0, OP_W'(r_yaw), w_dt);
                STP_SPD_YAW: w_op = mk_op(1'b1, 1'b0, 1'b0, OP_W'(r_spd), OP_W'(r_yaw));
                STP_DYAW_LO: w_op = mk_op(1'b1, 1'b0, 1'b0, lo32(r_dyaw[31:0]),
                                          $signed({4'd0, ulms_pkg::INV_TWO_PI_Q32}));
                STP_DYAW_HI: w_op = mk_op(1'b0, 1'b0, 1'b1, OP_W'($signed(r_dyaw[47:32])),
                                          $signed({4'd0, ulms_pkg::INV_TWO_PI_Q32}));
                STP_QC_LO:   w_op = mk_op(1'b1, 1'b0, 1'b0, lo32(r_q[31:0]), OP_W'(r_cos));
                STP_QC_HI:   w_op = mk_op(1'b0, 1'b0, 1'b1, OP_W'($signed(r_q[47:32])),
                                          OP_W'(r_cos));
                STP_QS_LO:   w_op = mk_op(1'b1, 1'b0, 1'b0, lo32(r_q[31:0]), OP_W'(r_sin));
                STP_QS_HI:   w_op = mk_op(1'b0, 1'b0, 1'b1, OP_W'($signed(r_q[47:32])),
                                          OP_W'(r_sin));
                STP_AXC_LO:  w_op = mk_op(1'b1, 1'b0, 1'b0, lo32(r_acc[31:0]), OP_W'(r_cos));
                STP_AXC_HI:  w_op = mk_op(1'b0, 1'b0, 1'b1, OP_W'($signed(r_acc[41:32])),
                                          OP_W'(r_cos));
                STP_AXS_LO:  w_op = mk_op(1'b0, 1'b1, 1'b0, lo32(r_om[31:0]), OP_W'(r_sin));
                STP_AXS_HI:  w_op = mk_op(1'b0, 1'b1, 1'b1, OP_W'($signed(r_om[47:32])),
                                          OP_W'(r_sin));
                STP_AYS_LO:  w_op = mk_op(1'b1, 1'b0, 1'b0, lo32(r_acc[31:0]), OP_W'(r_sin));
                STP_AYS_HI:  w_op = mk_op(1'b0, 1'b0, 1'b1, OP_W'($signed(r_acc[41:32])),
                                          OP_W'(r_sin));
                STP_AYC_LO:  w_op = mk_op(1'b0, 1'b0, 1'b0, lo32(r_om[31:0]), OP_W'(r_cos));
                STP_AYC_HI:  w_op = mk_op(1'b0, 1'b0, 1'b1, OP_W'($signed(r_om[47:32])),
                                          OP_W'(r_cos));
                default:     w_op = mk_op(1'b0, 1'b0, 1'b0, '0, '0);
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = i_in_data.restart ? ST_FIN : ST_CALC;
                end
            end
            ST_CALC: begin
                if (r_step == STP_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control, configuration and model state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_step            <= '0;
            r_out_valid       <= 1'b0;
            r_time_step       <= 16'd655;
            r_speed_lag_inv   <= 24'd936229;
            r_yaw_lag_inv     <= 24'd936229;
            r_start_x         <= '0;
            r_start_y         <= '0;
            r_start_heading   <= '0;
            r_start_speed     <= '0;
            r_start_turn_rate <= '0;
            r_x               <= '0;
            r_y               <= '0;
            r_hd              <= '0;
            r_spd             <= '0;
            r_yaw             <= '0;
            r_time            <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    ulms_pkg::REG_TIME_STEP:       r_time_step       <= i_cfg_data[15:0];
                    ulms_pkg::REG_SPEED_LAG_INV:   r_speed_lag_inv   <= i_cfg_data[23:0];
                    ulms_pkg::REG_YAW_LAG_INV:     r_yaw_lag_inv     <= i_cfg_data[23:0];
                    ulms_pkg::REG_START_X:         r_start_x         <= i_cfg_data;
                    ulms_pkg::REG_START_Y:         r_start_y         <= i_cfg_data;
                    ulms_pkg::REG_START_HEADING:   r_start_heading   <= i_cfg_data;
                    ulms_pkg::REG_START_SPEED:     r_start_speed     <= i_cfg_data;
                    ulms_pkg::REG_START_TURN_RATE: r_start_turn_rate <= i_cfg_data;
                    default: ;
                endcase
            end

            // drop the result word once taken; refill from the finished step
            if (r_state == ST_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == ST_IDLE && w_in_acc) begin
                r_step <= '0;
                if (i_in_data.restart) begin
                    // load the start pose and clear time
                    r_x    <= r_start_x;
                    r_y    <= r_start_y;
                    r_hd   <= r_start_heading;
                    r_spd  <= r_start_speed;
                    r_yaw  <= r_start_turn_rate;
                    r_time <= '0;
                end
            end

            if (r_state == ST_CALC) begin
                r_step <= r_step + 6'd1;
                // lagged speed: spd += floor(acc*dt/2^16), saturated
                if (r_step == STP_YACC_HI) begin
                    r_spd <= sat32(70'(w_acc >>> 16) + 70'(r_spd));
                end
                if (r_step == STP_YAW_CAP) begin
                    r_yaw <= sat32(70'(w_acc >>> 16) + 70'(r_yaw));
                end
                // heading advances by floor(yaw*dt*K/2^32), wrapping
                if (r_step == STP_HD_CAP) begin
                    r_hd <= r_hd + w_acc[63:32];
                end
                if (r_step == STP_QS_HI) begin
                    r_x <= sat32(70'(w_acc >>> 32) + 70'(r_x));
                end
                if (r_step == STP_AXC_HI) begin
                    r_y <= sat32(70'(w_acc >>> 32) + 70'(r_y));
                end
                if (r_step == STP_LAST) begin
                    r_time <= r_time + 32'(r_time_step);
                end
            end
        end
    end

    // Working values and the result word
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_in_acc) begin
            r_vcmd <= i_in_data.speed_cmd;
            r_wcmd <= i_in_data.turn_rate_cmd;
            r_ax   <= '0;
            r_ay   <= '0;
        end
        if (r_state == ST_CALC) begin
            if (r_step == STP_ACC_CAP) begin
                r_acc <= w_acc[57:16];
            end
            if (r_step == STP_ACC_LO) begin
                r_yacc <= w_acc[57:16];
            end
            if (r_step == STP_YAW_DT) begin
                r_q <= w_acc[47:0];
            end
            if (r_step == STP_DYAW_CAP) begin
                r_dyaw <= w_acc[47:0];
            end
            if (r_step == STP_DYAW_LO) begin
                r_om <= w_acc[63:16];
            end
            if (r_step == STP_COS_ADR) begin
                r_sin <= w_rom_data;
            end
            if (r_step == STP_COS_CAP) begin
                r_cos <= w_rom_data;
            end
            if (r_step == STP_AYS_HI) begin
                r_ax <= sat32(70'(w_acc >>> 16));
            end
            if (r_step == STP_LAST) begin
                r_ay <= sat32(70'(w_acc >>> 16));
            end
        end
        if (r_state == ST_FIN && w_out_free) begin
            r_out_data.elapsed   <= r_time;
            r_out_data.pos_x     <= r_x;
            r_out_data.pos_y     <= r_y;
            r_out_data.heading   <= r_hd;
            r_out_data.speed     <= r_spd;
            r_out_data.turn_rate <= r_yaw;
            r_out_data.accel_x   <= r_ax;
            r_out_data.accel_y   <= r_ay;
        end
    end

endmodule
